>>> rtl/lkvc_pkg.sv
package lkvc_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 64;

	// Widths of the external fields.
	localparam int KEY_PORT_W   = 64;
	localparam int VALUE_PORT_W = 64;
	localparam int CAP_W        = 5;

	// Index of one cell, and a count that can hold ENTRIES itself.
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	// Contents of one cell, also what a cell hands to its neighbor.
	typedef struct packed {
		logic                  valid;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic cmp;
		logic load;
	} cell_ctl_t;

endpackage

>>> rtl/lru_key_value_cache_top.sv
// Fully associative key-value cache with least-recently-used replacement.
// A request is taken when start is high and busy is low. It keeps the
// cache busy until its result is registered. First every cell compares
// its stored key with the request key. Then the row of cells shifts to
// move the touched entry to the front, and the result is registered.
// Busy falls at the same time, so a new request is taken only once the
// last one is through. The result shows on hit and read_value for exactly
// one cycle with done high. That is the same cycle in which the next
// request may already be accepted. The receiver cannot stall the cache,
// so it must take every result in the cycle that done marks. The capacity
// register may be written only while the cache is idle. Values above the
// number of cells act as the full size, and zero makes every request miss
// without changing the contents.
module lru_key_value_cache_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic [lkvc_pkg::KEY_PORT_W-1:0]     key,
	input  logic [lkvc_pkg::VALUE_PORT_W-1:0]   value,
	input  logic                                cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]          cfg_wdata,
	output logic                                done,
	output logic                                hit,
	output logic [lkvc_pkg::VALUE_PORT_W-1:0]   read_value
);

	localparam int N = lkvc_pkg::ENTRIES;

	// Request registers.
	logic                            busy_q;
	logic                            phase_q;
	logic                            op_q;
	logic [lkvc_pkg::KEY_BITS-1:0]   key_q;
	logic [lkvc_pkg::VALUE_BITS-1:0] value_q;

	logic [lkvc_pkg::CAP_W-1:0]      capacity_q;
	logic [lkvc_pkg::CNT_W-1:0]      used_q;

	logic                            done_q;
	logic                            hit_q;
	logic [lkvc_pkg::VALUE_BITS-1:0] read_value_q;

	// Cell row.
	lkvc_pkg::entry_t    nb   [N];
	lkvc_pkg::entry_t    ent  [N];
	lkvc_pkg::cell_ctl_t ctl  [N];
	logic [N-1:0]        match;

	// Update cycle decode.
	logic                            accept;
	logic                            upd_cycle;
	logic [lkvc_pkg::CNT_W-1:0]      cap_eff;
	logic                            enabled;
	logic                            any_hit;
	logic [lkvc_pkg::IDX_W-1:0]      hit_idx;
	logic [lkvc_pkg::VALUE_BITS-1:0] hit_val;
	logic                            room;
	logic [lkvc_pkg::CNT_W-1:0]      limit;
	logic                            update;
	lkvc_pkg::entry_t                new_entry;

	assign accept    = start && !busy_q;
	assign upd_cycle = busy_q && phase_q;

	always_comb begin
		if (int'(capacity_q) > N) begin
			cap_eff = lkvc_pkg::CNT_W'(N);
		end else begin
			cap_eff = lkvc_pkg::CNT_W'(capacity_q);
		end
	end

	assign enabled = (cap_eff != '0);
	assign any_hit = |match;
	assign room    = (used_q < cap_eff);

	// Keys are unique in the row, so at most one cell matches and the
	// index and value can be gathered by plain OR.
	always_comb begin
		hit_idx = '0;
		hit_val = '0;
		for (int j = 0; j < N; j++) begin
			if (match[j]) begin
				hit_idx = hit_idx | lkvc_pkg::IDX_W'(j);
				hit_val = hit_val | ent[j].value;
			end
		end
	end

	// Cells at or in front of the limit shift back by one place. On a hit
	// the limit is the hit cell; on a fill it is the first empty cell; on
	// an eviction it is the least recent cell, which drops out.
	always_comb begin
		priority if (any_hit) begin
			limit = lkvc_pkg::CNT_W'(hit_idx);
		end else if (room) begin
			limit = used_q;
		end else begin
			limit = used_q - lkvc_pkg::CNT_W'(1);
		end
	end

	assign update = upd_cycle && enabled && (any_hit || (op_q == lkvc_pkg::OP_SET));

	assign new_entry.valid = 1'b1;
	assign new_entry.key   = key_q;
	assign new_entry.value = (op_q == lkvc_pkg::OP_SET) ? value_q : hit_val;

	for (genvar j = 0; j < N; j++) begin : g_cell
		if (j == 0) begin : g_head
			assign nb[j] = new_entry;
		end else begin : g_body
			assign nb[j] = ent[j-1];
		end

		assign ctl[j].cmp  = busy_q && !phase_q;
		assign ctl[j].load = update && (lkvc_pkg::CNT_W'(j) <= limit);

		lkvc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[j]),
			.key_in (key_q),
			.nb_in  (nb[j]),
			.match  (match[j]),
			.ent    (ent[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			phase_q    <= 1'b0;
			capacity_q <= lkvc_pkg::CAP_RESET;
			used_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			done_q <= upd_cycle;
			if (accept) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
			end else if (busy_q && !phase_q) begin
				phase_q <= 1'b1;
			end else if (upd_cycle) begin
				busy_q  <= 1'b0;
				phase_q <= 1'b0;
			end
			if (update && !any_hit && room) begin
				used_q <= used_q + lkvc_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			key_q   <= key[lkvc_pkg::KEY_BITS-1:0];
			value_q <= value[lkvc_pkg::VALUE_BITS-1:0];
		end
		if (upd_cycle) begin
			hit_q <= enabled && any_hit;
			if (enabled && any_hit && (op_q == lkvc_pkg::OP_GET)) begin
				read_value_q <= hit_val;
			end else begin
				read_value_q <= '0;
			end
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign hit        = hit_q;
	assign read_value = lkvc_pkg::VALUE_PORT_W'(read_value_q);

endmodule

>>> rtl/lkvc_cell.sv
// One cache entry. Cells sit in recency order; a load takes the entry of
// the neighbor on the more recent side, or the new entry at the head.
module lkvc_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lkvc_pkg::cell_ctl_t            ctl,
	input  logic [lkvc_pkg::KEY_BITS-1:0]  key_in,
	input  lkvc_pkg::entry_t               nb_in,
	output logic                           match,
	output lkvc_pkg::entry_t               ent
);

	logic                            valid_q;
	logic                            match_q;
	logic [lkvc_pkg::KEY_BITS-1:0]   key_q;
	logic [lkvc_pkg::VALUE_BITS-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.cmp) begin
				match_q <= valid_q && (key_q == key_in);
			end
			if (ctl.load) begin
				valid_q <= nb_in.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			key_q   <= nb_in.key;
			value_q <= nb_in.value;
		end
	end

	assign match     = match_q;
	assign ent.valid = valid_q;
	assign ent.key   = key_q;
	assign ent.value = value_q;

endmodule

>>> test/lru_key_value_cache_top_test.sv
// Self-checking testbench for the LRU key-value cache.
//
// The stimulus runs as a sequence of named tests. Every test drives requests
// through one shared task, and one checking process compares every result
// that the cache marks with done against a predictor that runs alongside.
//
// The predictor keeps the cache contents as a queue ordered by recency. The
// front is the most recent entry and the back is the least recent. The order
// is all that can be observed through hit and read_value, so it does not try
// to follow the physical cell positions inside the cache.
module lru_key_value_cache_top_test;
	import lkvc_pkg::*;

	// One cached line as the predictor holds it.
	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} cache_line_t;

	// One result as the cache should report it.
	typedef struct packed {
		logic                    hit;
		logic [VALUE_PORT_W-1:0] read_value;
	} lookup_result_t;

	// This limit leaves a wide margin over the slowest correct run while still
	// catching a cache that hangs.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int KEY_POOL_SIZE = 32;

	localparam logic [KEY_PORT_W-1:0]   KEY_ZERO   = '0;
	localparam logic [KEY_PORT_W-1:0]   KEY_ONES   = '1;
	localparam logic [KEY_PORT_W-1:0]   KEY_ALT    = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [KEY_PORT_W-1:0]   KEY_FIRST  = 64'h0123_4567_89AB_CDEF;
	localparam logic [KEY_PORT_W-1:0]   KEY_SECOND = 64'hFEDC_BA98_7654_3210;
	localparam logic [VALUE_PORT_W-1:0] VALUE_ZERO = '0;
	localparam logic [VALUE_PORT_W-1:0] VALUE_ONES = '1;
	localparam logic [VALUE_PORT_W-1:0] VALUE_ALT  = 64'h5555_5555_5555_5555;

	// Every input holds a known value from time zero.
	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    start     = 1'b0;
	logic                    op        = OP_GET;
	logic [KEY_PORT_W-1:0]   key       = '0;
	logic [VALUE_PORT_W-1:0] value     = '0;
	logic                    cfg_we    = 1'b0;
	logic [CAP_W-1:0]        cfg_wdata = '0;

	wire                    busy;
	wire                    done;
	wire                    hit;
	wire [VALUE_PORT_W-1:0] read_value;

	// Shadow state of the predictor: the recency order, the capacity
	// register, and the results that are owed by the cache, oldest first.
	cache_line_t    recency_list[$];
	lookup_result_t pending_results[$];
	logic [CAP_W-1:0] capacity_shadow = CAP_RESET;

	logic [KEY_PORT_W-1:0] key_pool[KEY_POOL_SIZE];

	int error_count   = 0;
	int request_count = 0;
	int result_count  = 0;
	int hit_count     = 0;
	int cycle_count   = 0;
	int idle_percent  = 0;

	lru_key_value_cache_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.key        (key),
		.value      (value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.hit        (hit),
		.read_value (read_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the result of one accepted request and updates the recency
	// order the same way the cache is meant to.
	function automatic lookup_result_t predict_access(input logic req_op,
			input logic [KEY_PORT_W-1:0] req_key, input logic [VALUE_PORT_W-1:0] req_value);
		lookup_result_t res;
		cache_line_t    line;
		int             usable;
		int             slot;
		res = '0;
		// Settings above the number of cells act as the full size.
		usable = (capacity_shadow > ENTRIES) ? ENTRIES : int'(capacity_shadow);
		// A disabled cache misses everything and keeps its contents untouched,
		// so they come back when the capacity is raised again.
		if (usable == 0)
			return res;
		slot = -1;
		foreach (recency_list[i])
			if (slot < 0 && recency_list[i].key == req_key[KEY_BITS-1:0])
				slot = i;
		line.key   = req_key[KEY_BITS-1:0];
		line.value = req_value[VALUE_BITS-1:0];
		if (slot >= 0) begin
			// A hit of either kind moves the line to the most recent end. A get
			// reads the stored value; a set replaces it and reads back zero.
			res.hit = 1'b1;
			if (req_op == OP_GET) begin
				res.read_value = VALUE_PORT_W'(recency_list[slot].value);
				line.value     = recency_list[slot].value;
			end
			recency_list.delete(slot);
			recency_list.push_front(line);
			return res;
		end
		// A set that misses fills a free entry while the list is shorter than
		// the capacity. Otherwise it replaces the least recent entry, which
		// also covers a capacity lowered below the number of lines held.
		if (req_op == OP_SET) begin
			if (recency_list.size() >= usable)
				recency_list.delete(recency_list.size() - 1);
			recency_list.push_front(line);
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [VALUE_PORT_W-1:0] wanted,
			input logic [VALUE_PORT_W-1:0] got);
		$display("MISMATCH at result %0d, %s: expected %h, got %h", result_count, what,
			wanted, got);
		error_count++;
	endtask

	// Drives one request and holds it until the cache takes it. The predictor
	// runs at the same edge at which the request is accepted. Afterward the
	// sender may go idle for a while; with no gap, start simply stays high
	// for the next request.
	task automatic send_request(input logic req_op, input logic [KEY_PORT_W-1:0] req_key,
			input logic [VALUE_PORT_W-1:0] req_value);
		start <= 1'b1;
		op    <= req_op;
		key   <= req_key;
		value <= req_value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(predict_access(req_op, req_key, req_value));
		request_count++;
		while ($urandom_range(99) < idle_percent) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stops sending and waits until every owed result has come back and the
	// cache reports that it is no longer busy.
	task automatic wait_until_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// The capacity register is only written while the cache is idle.
	task automatic write_capacity(input logic [CAP_W-1:0] setting);
		wait_until_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= setting;
		@(posedge clk);
		capacity_shadow = setting;
		cfg_we <= 1'b0;
	endtask

	// This runs straight after reset, while the cache is still empty, because
	// that is the only time one line can be both in use and the only one.
	// A set that misses must then overwrite that line, and the line must stay
	// both most and least recent.
	task automatic test_single_entry();
		idle_percent = 0;
		write_capacity(5'd1);
		send_request(OP_GET, KEY_FIRST, VALUE_ONES);
		send_request(OP_SET, KEY_FIRST, VALUE_ALT);
		send_request(OP_GET, KEY_FIRST, VALUE_ZERO);
		send_request(OP_SET, KEY_ONES, VALUE_ZERO);
		send_request(OP_GET, KEY_FIRST, VALUE_ZERO);
		send_request(OP_GET, KEY_ONES, VALUE_ZERO);
		send_request(OP_SET, KEY_ONES, VALUE_ONES);
		send_request(OP_GET, KEY_ONES, VALUE_ZERO);
	endtask

	// With a capacity of zero everything misses and nothing is stored. The
	// earlier contents must come back once the capacity is raised again.
	task automatic test_capacity_zero();
		write_capacity(5'd0);
		send_request(OP_GET, KEY_ONES, VALUE_ZERO);
		send_request(OP_SET, KEY_SECOND, VALUE_ONES);
		write_capacity(5'd16);
		send_request(OP_GET, KEY_ONES, VALUE_ZERO);
		send_request(OP_GET, KEY_SECOND, VALUE_ZERO);
	endtask

	// All-zero and all-one keys and values, alternating bit patterns, and a
	// get whose ignored value field is all ones.
	task automatic test_field_extremes();
		send_request(OP_SET, KEY_ZERO, VALUE_ONES);
		send_request(OP_SET, KEY_ONES, VALUE_ALT);
		send_request(OP_GET, KEY_ZERO, VALUE_ONES);
		send_request(OP_SET, KEY_ALT, VALUE_ALT);
		send_request(OP_GET, KEY_ALT, VALUE_ONES);
		send_request(OP_GET, KEY_ONES, VALUE_ZERO);
	endtask

	// Lowering the capacity below the number of lines held keeps them all
	// reachable, and a set that misses then evicts the least recent one.
	// The setting above the number of cells is written here as well.
	task automatic test_shrink_below_fill();
		write_capacity(5'd2);
		send_request(OP_GET, KEY_ZERO, VALUE_ZERO);
		send_request(OP_SET, KEY_SECOND, VALUE_ZERO);
		send_request(OP_GET, KEY_ONES, VALUE_ZERO);
		send_request(OP_GET, KEY_ALT, VALUE_ZERO);
		write_capacity(5'd31);
		send_request(OP_GET, KEY_SECOND, VALUE_ZERO);
	endtask

	// Random gets and sets. Most keys come from a pool a little larger than
	// the capacity, so hits, fills, updates and evictions all happen often.
	// Now and then a fresh random key is mixed in.
	task automatic test_random_traffic(input int gap_percent, input logic [CAP_W-1:0] setting,
			input int count);
		int                      span;
		logic                    req_op;
		logic [KEY_PORT_W-1:0]   req_key;
		logic [VALUE_PORT_W-1:0] req_value;
		write_capacity(setting);
		idle_percent = gap_percent;
		span = (setting == 0) ? 8 : ((setting > ENTRIES) ? ENTRIES : int'(setting)) * 3 / 2 + 2;
		if (span > KEY_POOL_SIZE)
			span = KEY_POOL_SIZE;
		repeat (count) begin
			req_op = $urandom_range(1) ? OP_SET : OP_GET;
			if ($urandom_range(15) == 0)
				req_key = {$urandom, $urandom};
			else
				req_key = key_pool[$urandom_range(span - 1)];
			case ($urandom_range(7))
				0: req_value = VALUE_ZERO;
				1: req_value = VALUE_ONES;
				default: req_value = {$urandom, $urandom};
			endcase
			send_request(req_op, req_key, req_value);
		end
		idle_percent = 0;
	endtask

	// Every result the cache marks with done must match the oldest result
	// that is still owed. Since the receiver cannot hold results off, the
	// check runs at every edge at which done is high.
	always @(posedge clk) begin : check_results
		lookup_result_t wanted;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no request pending", '0, read_value);
			end else begin
				wanted = pending_results.pop_front();
				if (hit !== wanted.hit)
					report_mismatch("hit", VALUE_PORT_W'(wanted.hit), VALUE_PORT_W'(hit));
				if (read_value !== wanted.read_value)
					report_mismatch("read_value", wanted.read_value, read_value);
				if (wanted.hit)
					hit_count++;
			end
			result_count++;
		end
	end

	// Guard against a cache that stops answering.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		// Keys zero and all ones sit in the pool, so the random part hits the
		// extremes too. The rest are random 64-bit words.
		key_pool[0] = KEY_ZERO;
		key_pool[1] = KEY_ONES;
		for (int i = 2; i < KEY_POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};

		// Reset is held low from time zero and released on a clock edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_entry();
		test_capacity_zero();
		test_field_extremes();
		test_shrink_below_fill();

		// Random phases over several capacities. Each phase either keeps
		// start high all the time or lets the sender go idle at random.
		test_random_traffic(0, 5'd31, 300);
		test_random_traffic(46, 5'd2, 250);
		test_random_traffic(46, 5'd8, 300);
		test_random_traffic(37, 5'd17, 250);
		test_random_traffic(0, 5'd0, 100);
		test_random_traffic(46, 5'd1, 150);
		test_random_traffic(37, 5'd16, 200);
		test_random_traffic(0, 5'd5, 150);

		wait_until_idle();
		repeat (10) @(posedge clk);

		$display("Ran %0d requests and checked %0d results, %0d of them hits,", request_count,
			result_count, hit_count);
		$display("over capacities 0, 1, 2, 5, 8, 16, 17 and 31, with and without sender gaps.");
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/lkvc_pkg.sv
rtl/lkvc_cell.sv
rtl/lru_key_value_cache_top.sv
test/lru_key_value_cache_top_test.sv
